@@ design/prvd_pkg.sv @@
package prvd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValW    = 32;
  localparam int unsigned TagW    = 8;
  localparam int unsigned PayW    = 7;
  localparam int unsigned KindW   = 3;
  // five payload groups at most per varbyte number
  localparam int unsigned GrpW    = 3;
  localparam logic [GrpW-1:0] LastGroup = 3'd4;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  typedef enum logic [KindW-1:0] {
    KindLen   = 3'd0,
    KindByte  = 3'd1,
    KindCount = 3'd2,
    KindPost  = 3'd3,
    KindOvf   = 3'd4,
    KindTrunc = 3'd5
  } kind_e;

  // classified item as held in the queue
  typedef struct packed {
    logic            is_end;
    logic            cont;
    logic [PayW-1:0] payload;
    logic [TagW-1:0] tag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

endpackage

@@ design/prvd_if.sv @@
interface prvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_end;
  logic [7:0] source_index;

  modport source (output valid, data_byte, is_end, source_index, input ready);
  modport sink (input valid, data_byte, is_end, source_index, output ready);
endinterface

interface prvd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [31:0] doc_id;
  logic [7:0]  source_tag;
  logic        record_last;

  modport source (output valid, kind, value, doc_id, source_tag, record_last, input ready);
  modport sink (input valid, kind, value, doc_id, source_tag, record_last, output ready);
endinterface

@@ design/prvd_front.sv @@
module prvd_front (
  prvd_in_if.sink        in_i,
  input  logic           q_ready_i,
  output prvd_pkg::q_wr_t q_wr_o
);
  import prvd_pkg::*;

  // split the raw byte into continuation flag and payload group
  assign in_i.ready           = q_ready_i;
  assign q_wr_o.valid         = in_i.valid;
  assign q_wr_o.item.is_end   = in_i.is_end;
  assign q_wr_o.item.cont     = in_i.data_byte[ByteW-1];
  assign q_wr_o.item.payload  = in_i.data_byte[PayW-1:0];
  assign q_wr_o.item.tag      = in_i.source_index;

endmodule

@@ design/prvd_queue.sv @@
module prvd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prvd_pkg::q_wr_t wr_i,
  output logic            wr_ready_o,
  output prvd_pkg::q_rd_t rd_o,
  input  logic            rd_ready_i
);
  import prvd_pkg::*;

  item_t              mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign do_wr      = wr_i.valid && wr_ready_o;
  assign do_rd      = rd_o.valid && rd_ready_i;
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

endmodule

@@ design/prvd_back.sv @@
module prvd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prvd_pkg::q_rd_t rd_i,
  output logic            rd_ready_o,
  prvd_out_if.source      out_o
);
  import prvd_pkg::*;

  typedef enum logic [2:0] {
    PhLen   = 3'd0,
    PhTerm  = 3'd1,
    PhCount = 3'd2,
    PhDelta = 3'd3,
    PhFreq  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [GrpW-1:0]   grp_q, grp_d;
  logic [ValW-1:0]   tbl_q, tbl_d;
  logic [ValW-1:0]   pl_q, pl_d;
  logic [ValW-1:0]   prev_q, prev_d;
  logic [ValW-1:0]   held_q, held_d;

  logic              ov_q, ov_d;
  kind_e             kind_q, kind_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [ValW-1:0]   doc_q, doc_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic              last_q, last_d;

  logic              fire;
  logic [ValW-1:0]   shifted, num, doc_sum, tbl_dec, pl_dec;
  item_t             it;

  assign it         = rd_i.item;
  assign rd_ready_o = !ov_q || out_o.ready;
  assign fire       = rd_i.valid && rd_ready_o;

  // place the payload group; the fifth group keeps only bits 28..31
  always_comb begin
    case (grp_q)
      3'd0:    shifted = {25'd0, it.payload};
      3'd1:    shifted = {18'd0, it.payload, 7'd0};
      3'd2:    shifted = {11'd0, it.payload, 14'd0};
      3'd3:    shifted = {4'd0, it.payload, 21'd0};
      default: shifted = {it.payload[3:0], 28'd0};
    endcase
  end

  assign num     = acc_q | shifted;
  assign doc_sum = prev_q + held_q;
  assign tbl_dec = tbl_q - 1'b1;
  assign pl_dec  = pl_q - 1'b1;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    grp_d   = grp_q;
    tbl_d   = tbl_q;
    pl_d    = pl_q;
    prev_d  = prev_q;
    held_d  = held_q;
    ov_d    = ov_q && !out_o.ready;
    kind_d  = kind_q;
    val_d   = val_q;
    doc_d   = doc_q;
    tag_d   = tag_q;
    last_d  = last_q;

    if (fire) begin
      tag_d  = it.tag;
      val_d  = '0;
      doc_d  = '0;
      last_d = 1'b0;
      if (it.is_end) begin
        // end between records is silent
        if (!(phase_q == PhLen && grp_q == '0 && acc_q == '0)) begin
          phase_d = PhLen;
          acc_d   = '0;
          grp_d   = '0;
          tbl_d   = '0;
          pl_d    = '0;
          prev_d  = '0;
          held_d  = '0;
          ov_d    = 1'b1;
          kind_d  = KindTrunc;
          last_d  = 1'b1;
        end
      end else if (phase_q == PhTerm) begin
        tbl_d = tbl_dec;
        if (tbl_dec == '0) begin
          phase_d = PhCount;
        end
        ov_d   = 1'b1;
        kind_d = KindByte;
        val_d  = {24'd0, it.cont, it.payload};
      end else if (it.cont) begin
        if (grp_q == LastGroup) begin
          // sixth byte would follow: overflow
          phase_d = PhLen;
          acc_d   = '0;
          grp_d   = '0;
          tbl_d   = '0;
          pl_d    = '0;
          prev_d  = '0;
          held_d  = '0;
          ov_d    = 1'b1;
          kind_d  = KindOvf;
          last_d  = 1'b1;
        end else begin
          acc_d = num;
          grp_d = grp_q + 1'b1;
        end
      end else begin
        acc_d = '0;
        grp_d = '0;
        case (phase_q)
          PhCount: begin
            pl_d    = num;
            prev_d  = '0;
            phase_d = (num == '0) ? PhLen : PhDelta;
            ov_d    = 1'b1;
            kind_d  = KindCount;
            val_d   = num;
            last_d  = (num == '0);
          end
          PhDelta: begin
            held_d  = num;
            phase_d = PhFreq;
          end
          PhFreq: begin
            held_d = '0;
            pl_d   = pl_dec;
            ov_d   = 1'b1;
            kind_d = KindPost;
            val_d  = num;
            doc_d  = doc_sum;
            if (pl_dec == '0) begin
              prev_d  = '0;
              phase_d = PhLen;
              last_d  = 1'b1;
            end else begin
              prev_d  = doc_sum;
              phase_d = PhDelta;
            end
          end
          default: begin
            // term length, also any unused phase code
            prev_d  = '0;
            tbl_d   = num;
            phase_d = (num == '0) ? PhCount : PhTerm;
            ov_d    = 1'b1;
            kind_d  = KindLen;
            val_d   = num;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLen;
      acc_q   <= '0;
      grp_q   <= '0;
      tbl_q   <= '0;
      pl_q    <= '0;
      prev_q  <= '0;
      held_q  <= '0;
      ov_q    <= 1'b0;
      kind_q  <= KindLen;
      val_q   <= '0;
      doc_q   <= '0;
      tag_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      grp_q   <= grp_d;
      tbl_q   <= tbl_d;
      pl_q    <= pl_d;
      prev_q  <= prev_d;
      held_q  <= held_d;
      ov_q    <= ov_d;
      kind_q  <= kind_d;
      val_q   <= val_d;
      doc_q   <= doc_d;
      tag_q   <= tag_d;
      last_q  <= last_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.kind        = kind_q;
  assign out_o.value       = val_q;
  assign out_o.doc_id      = doc_q;
  assign out_o.source_tag  = tag_q;
  assign out_o.record_last = last_q;

endmodule

@@ design/posting_record_varbyte_decoder_core.sv @@
// Decodes a byte stream of posting records (term length, term bytes, posting
// count, then delta/frequency pairs, all little-endian varbyte numbers) into
// one result per completed field: length, each term byte, count, and each
// posting with its absolute document id. record_last marks the final result of
// a record and every error; a fifth byte with its continuation bit set gives
// an overflow error and an end item inside a record a truncation error, both
// restarting the parser. Throughput is one input item per clock while the output
// accepts results; the back end updates accumulator, phase and doc-id add once
// per item. An accepted item is written into the queue, then decoded into the
// output register when the output is free; a two-entry queue between front and
// back absorbs output stalls so the input still takes items while a result waits.
module posting_record_varbyte_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  prvd_in_if.sink    in_i,
  prvd_out_if.source out_o
);
  import prvd_pkg::*;

  // front to queue
  q_wr_t q_wr;
  logic  q_wr_ready;
  // queue to back
  q_rd_t q_rd;
  logic  q_rd_ready;

  // front: takes items and splits each byte into flag and payload
  prvd_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_wr_ready),
    .q_wr_o    (q_wr)
  );

  // short queue decoupling input acceptance from output stalls
  prvd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_ready_o (q_wr_ready),
    .rd_o       (q_rd),
    .rd_ready_i (q_rd_ready)
  );

  // back: record parser and registered result
  prvd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (q_rd),
    .rd_ready_o (q_rd_ready),
    .out_o      (out_o)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import prvd_pkg::*;

  // cycles with no item moving on either side before the run is called hung
  localparam int unsigned StallLimit  = 1000;
  // the block holds at most a few items (two-entry queue plus pipeline)
  localparam int unsigned TailCycles  = 20;
  // byte items to send in the random stream
  localparam int unsigned RandomItems = 1350;
  // long receiver hold-off that fills the block
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned PressurePostings = 24;

  localparam logic [5:0] GroupStep  = 6'd7;
  localparam logic [5:0] ShiftLimit = 6'd35;

  // parser position within a record
  typedef enum logic [2:0] {
    PhLen,
    PhTerm,
    PhCount,
    PhDelta,
    PhFreq
  } rec_phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [31:0] doc_id;
    logic [7:0]  tag;
    logic        last;
  } posting_result_t;

  logic clk = 1'b0;
  logic rst_n;

  prvd_in_if  in_bus ();
  prvd_out_if out_bus ();

  posting_result_t pending_results[$];
  logic [7:0]      rec_bytes[$];

  int unsigned fail_count   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  // no random gaps on either side while set
  logic        calm = 1'b0;

  // decoder state as the block should hold it
  rec_phase_e  dec_phase;
  logic [31:0] vb_acc;
  logic [5:0]  vb_shift;
  logic [31:0] term_left;
  logic [31:0] postings_left;
  logic [31:0] doc_run;
  logic [31:0] delta_hold;

  posting_record_varbyte_decoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 127);
      1: return $urandom_range(0, 16383);
      2: return $urandom;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic clear_decoder();
    dec_phase     = PhLen;
    vb_acc        = '0;
    vb_shift      = '0;
    term_left     = '0;
    postings_left = '0;
    doc_run       = '0;
    delta_hold    = '0;
  endtask

  function automatic logic decoder_clean();
    return dec_phase == PhLen && vb_shift == '0 && vb_acc == '0;
  endfunction

  // append one raw byte to the record being built
  task automatic add_byte(input logic [7:0] b);
    rec_bytes = {rec_bytes, b};
  endtask

  // advance the decoder by one accepted item and queue the result it causes
  task automatic decode_item(input logic [7:0] b, input logic e, input logic [7:0] tag);
    posting_result_t res;
    logic [31:0]     num;
    logic            emit;
    res     = '0;
    res.tag = tag;
    emit    = 1'b0;
    if (e) begin
      // end item: quiet between records, truncation anywhere else
      if (!decoder_clean()) begin
        clear_decoder();
        res.kind = KindTrunc;
        res.last = 1'b1;
        emit     = 1'b1;
      end
    end else if (dec_phase == PhTerm) begin
      // term bytes are raw, the high bit means nothing here
      term_left = term_left - 1;
      if (term_left == '0) dec_phase = PhCount;
      res.kind  = KindByte;
      res.value = 32'(b);
      emit      = 1'b1;
    end else begin
      // fifth group lands at bit 28, bits above 31 fall off
      vb_acc = vb_acc | (32'(b[6:0]) << vb_shift);
      if (b[7]) begin
        vb_shift = vb_shift + GroupStep;
        if (vb_shift >= ShiftLimit) begin
          clear_decoder();
          res.kind = KindOvf;
          res.last = 1'b1;
          emit     = 1'b1;
        end
      end else begin
        num      = vb_acc;
        vb_acc   = '0;
        vb_shift = '0;
        emit     = 1'b1;
        case (dec_phase)
          PhLen: begin
            doc_run   = '0;
            term_left = num;
            dec_phase = (num == '0) ? PhCount : PhTerm;
            res.kind  = KindLen;
            res.value = num;
          end
          PhCount: begin
            postings_left = num;
            doc_run       = '0;
            dec_phase     = (num == '0) ? PhLen : PhDelta;
            res.kind      = KindCount;
            res.value     = num;
            res.last      = (num == '0);
          end
          PhDelta: begin
            // delta waits silently for its frequency
            delta_hold = num;
            dec_phase  = PhFreq;
            emit       = 1'b0;
          end
          default: begin
            doc_run       = doc_run + delta_hold;
            delta_hold    = '0;
            postings_left = postings_left - 1;
            res.kind      = KindPost;
            res.value     = num;
            res.doc_id    = doc_run;
            if (postings_left == '0) begin
              res.last  = 1'b1;
              doc_run   = '0;
              dec_phase = PhLen;
            end else begin
              dec_phase = PhDelta;
            end
          end
        endcase
      end
    end
    if (emit) pending_results = {pending_results, res};
  endtask

  // offer one item after a random gap and wait for the handshake
  task automatic send_item(input logic [7:0] b, input logic e);
    int         gap;
    logic [7:0] tag;
    gap = pick_gap();
    tag = 8'($urandom);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.is_end       <= e;
    in_bus.source_index <= tag;
    do @(posedge clk); while (!in_bus.ready);
    decode_item(b, e, tag);
    if (!e) bytes_sent++;
  endtask

  // end item; its data byte is junk the block ignores
  task automatic send_end();
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_rec_bytes();
    foreach (rec_bytes[i]) send_item(rec_bytes[i], 1'b0);
    rec_bytes.delete();
  endtask

  // little-endian varbyte, sometimes padded out with empty groups
  task automatic push_number(input logic [31:0] v);
    int         n;
    logic [6:0] grp;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(n, 5);
    for (int i = 0; i < n; i++) begin
      grp = 7'(v >> (7 * i));
      // bits 32..34 of a five-byte number are dropped, so fill them
      if (i == 4) grp[6:4] = 3'($urandom);
      add_byte({1'(i < n - 1), grp});
    end
  endtask

  // well-formed record; negative posting count means pick one at random
  task automatic build_record(input int posts);
    int len;
    int cnt;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    push_number(len);
    repeat (len) add_byte(8'($urandom));
    if (posts >= 0) cnt = posts;
    else cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    push_number(cnt);
    repeat (cnt) begin
      push_number(rand_value());
      push_number(rand_value());
    end
  endtask

  // bring the stream back to a record boundary
  task automatic resync();
    if (!decoder_clean()) send_end();
  endtask

  task automatic test_directed_record();
    // raw 0x00/0xff term bytes, two postings, max delta with dropped
    // high bits so the doc id wraps to 4
    rec_bytes = '{8'h02, 8'h00, 8'hFF, 8'h02, 8'h05, 8'h01,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    send_rec_bytes();
  endtask

  task automatic test_empty_records();
    // empty term then empty posting list, then a quiet end item
    rec_bytes = '{8'h00, 8'h00};
    send_rec_bytes();
    send_end();
  endtask

  task automatic test_error_cases();
    // sixth group would follow: overflow on the fifth byte
    rec_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_rec_bytes();
    // parser restarted: new length, then cut short
    rec_bytes = '{8'h01};
    send_rec_bytes();
    send_end();
    // partial varbyte with zero payload still counts as inside a record
    rec_bytes = '{8'h80};
    send_rec_bytes();
    send_end();
  endtask

  task automatic test_backpressure();
    // receiver stops while the sender streams a long record back to back
    calm         = 1'b1;
    hold_request = HoldCycles;
    build_record(PressurePostings);
    send_rec_bytes();
    calm = 1'b0;
  endtask

  task automatic test_random_stream();
    int sel;
    int keep;
    while (bytes_sent < RandomItems) begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      sel = $urandom_range(0, 99);
      build_record(-1);
      if (sel < 75) begin
        send_rec_bytes();
        if ($urandom_range(0, 19) == 0) send_end();
      end else if (sel < 92) begin
        keep = $urandom_range(0, rec_bytes.size() - 1);
        while (rec_bytes.size() > keep) rec_bytes.pop_back();
        // cut the record short, or push a run of continuation bytes into it
        if (sel >= 84) repeat (5) add_byte({1'b1, 7'($urandom)});
        send_rec_bytes();
        if (sel < 84) send_end();
        resync();
      end else begin
        // raw noise
        rec_bytes.delete();
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        send_rec_bytes();
        resync();
      end
    end
    calm = 1'b0;
    resync();
  endtask

  // receiver: random stalls, plus the long hold-off on request
  initial begin : drive_ready
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each delivered result with the oldest one pending
  always @(posedge clk) begin : check_results
    posting_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d value %h doc %h",
                 $time, out_bus.kind, out_bus.value, out_bus.doc_id);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_bus.kind));
        check_field("value", want.value, out_bus.value);
        check_field("doc_id", want.doc_id, out_bus.doc_id);
        check_field("source_tag", 32'(want.tag), 32'(out_bus.source_tag));
        check_field("record_last", 32'(want.last), 32'(out_bus.record_last));
      end
    end
  end

  // hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.data_byte    = '0;
    in_bus.is_end       = 1'b0;
    in_bus.source_index = '0;
    clear_decoder();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_record();
    test_empty_records();
    test_error_cases();
    test_backpressure();
    test_random_stream();

    in_bus.valid <= 1'b0;
    // drain, then give stray results a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
